### hdl/itc_pkg.sv
// Shared types and constants for the three-counter interval timer.
// No dependencies; used by every module under hdl/.
package itc_pkg;

    // number of counters in the timer
    localparam int NUM_COUNTERS = 3;

    // field widths
    localparam int CNT_W    = 17;   // live/latched count, two's complement
    localparam int RELOAD_W = 16;
    localparam int BYTE_W   = 8;
    localparam int OUT_W    = 16;   // result tdata width (irq + read byte, padded)

    // item kinds carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        OP_CTRL = 2'd0,
        OP_DATA = 2'd1,
        OP_READ = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    // access (read/write) modes from control word bits 5:4
    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_BOTH  = 2'd3
    } access_t;

    // counting modes from control word bits 3:1
    localparam logic [2:0] MODE_TERMINAL = 3'd0;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_SQUARE   = 3'd3;
    localparam logic [2:0] MODE_STROBE   = 3'd4;

    // fixed read bytes
    localparam logic [BYTE_W-1:0] RD_UNUSED_PORT = 8'h7E;
    localparam logic [BYTE_W-1:0] RD_LATCH_NOACC = 8'h7F;
    localparam logic [BYTE_W-1:0] RD_LIVE_NOACC  = 8'hFF;

    // counter select value with no counter behind it
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    // per-counter command, decoded from one accepted transfer
    typedef struct packed {
        logic wr_ctrl;
        logic wr_data;
        logic rd;
        logic step;
    } cnt_cmd_t;

    // per-counter response for the same transfer
    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              pulse;
    } cnt_rsp_t;

endpackage

### hdl/itc_counter.sv
// One timer counter: mode/access registers, count, reload, latch and byte toggle.
// Depends on itc_pkg.
module itc_counter #(
    parameter itc_pkg::access_t RST_ACCESS = itc_pkg::ACC_BOTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  itc_pkg::cnt_cmd_t             cmd,
    input  logic [itc_pkg::BYTE_W-1:0]    data_byte,
    output itc_pkg::cnt_rsp_t             rsp
);

    logic [2:0]                            count_mode_reg,  count_mode_next;
    itc_pkg::access_t                      access_mode_reg, access_mode_next;
    logic signed [itc_pkg::CNT_W-1:0]      live_reg,        live_next;
    logic [itc_pkg::RELOAD_W-1:0]          reload_reg,      reload_next;
    logic signed [itc_pkg::CNT_W-1:0]      latched_reg,     latched_next;
    logic                                  latch_pend_reg,  latch_pend_next;
    logic                                  toggle_reg,      toggle_next;
    logic                                  running_reg,     running_next;

    logic signed [itc_pkg::CNT_W-1:0]      dec;
    logic                                  load_ok;
    logic [1:0]                            cw_access;

    assign dec       = live_reg - 17'sd1;
    assign cw_access = data_byte[5:4];
    // a running rate or square-wave counter keeps its count on reload writes
    assign load_ok   = !running_reg || !(count_mode_reg inside {itc_pkg::MODE_RATE,
                                                                itc_pkg::MODE_SQUARE});

    always_comb begin
        count_mode_next  = count_mode_reg;
        access_mode_next = access_mode_reg;
        live_next        = live_reg;
        reload_next      = reload_reg;
        latched_next     = latched_reg;
        latch_pend_next  = latch_pend_reg;
        toggle_next      = toggle_reg;
        running_next     = running_reg;
        rsp              = '0;

        // tick
        if (cmd.step && running_reg) begin
            case (count_mode_reg)
                itc_pkg::MODE_TERMINAL: begin
                    if (live_reg <= 0) begin
                        rsp.pulse = 1'b1;
                        live_next = '0;
                    end else begin
                        live_next = dec;
                    end
                end
                itc_pkg::MODE_RATE: begin
                    if (dec <= 0) begin
                        rsp.pulse = 1'b1;
                        live_next = $signed({1'b0, reload_reg});
                    end else begin
                        live_next = dec;
                    end
                end
                itc_pkg::MODE_STROBE: begin
                    if (dec <= 0) begin
                        rsp.pulse = 1'b1;
                        live_next = '1;
                    end else begin
                        live_next = dec;
                    end
                end
                default: ;
            endcase
        end

        // control word addressed to this counter
        if (cmd.wr_ctrl) begin
            if (cw_access == itc_pkg::ACC_LATCH) begin
                latched_next    = live_reg;
                latch_pend_next = 1'b1;
            end else begin
                toggle_next      = 1'b0;
                latch_pend_next  = 1'b0;
                running_next     = 1'b0;
                access_mode_next = itc_pkg::access_t'(cw_access);
                count_mode_next  = data_byte[3:1];
            end
        end

        // count byte write
        if (cmd.wr_data) begin
            latch_pend_next = 1'b0;
            case (access_mode_reg)
                itc_pkg::ACC_LOW: begin
                    reload_next  = {8'h00, data_byte};
                    toggle_next  = 1'b0;
                    running_next = 1'b1;
                end
                itc_pkg::ACC_HIGH: begin
                    reload_next  = {data_byte, 8'h00};
                    toggle_next  = 1'b0;
                    running_next = 1'b1;
                end
                itc_pkg::ACC_BOTH: begin
                    if (toggle_reg) begin
                        reload_next  = {data_byte, reload_reg[7:0]};
                        running_next = 1'b1;
                    end else begin
                        reload_next  = {8'h00, data_byte};
                    end
                    toggle_next = !toggle_reg;
                end
                default: ;
            endcase
            if (access_mode_reg != itc_pkg::ACC_LATCH && load_ok)
                live_next = $signed({1'b0, reload_next});
        end

        // count read: latched value first if a latch is pending
        if (cmd.rd) begin
            if (latch_pend_reg) begin
                case (access_mode_reg)
                    itc_pkg::ACC_LOW: begin
                        latch_pend_next = 1'b0;
                        rsp.rdata       = latched_reg[7:0];
                    end
                    itc_pkg::ACC_HIGH: begin
                        latch_pend_next = 1'b0;
                        rsp.rdata       = latched_reg[15:8];
                    end
                    itc_pkg::ACC_BOTH: begin
                        toggle_next = !toggle_reg;
                        if (!toggle_reg) begin
                            rsp.rdata = latched_reg[7:0];
                        end else begin
                            latch_pend_next = 1'b0;
                            rsp.rdata       = latched_reg[15:8];
                        end
                    end
                    default: rsp.rdata = itc_pkg::RD_LATCH_NOACC;
                endcase
            end else begin
                case (access_mode_reg)
                    itc_pkg::ACC_LOW:  rsp.rdata = live_reg[7:0];
                    itc_pkg::ACC_HIGH: rsp.rdata = live_reg[15:8];
                    itc_pkg::ACC_BOTH: begin
                        toggle_next = !toggle_reg;
                        rsp.rdata   = toggle_reg ? live_reg[15:8] : live_reg[7:0];
                    end
                    default: rsp.rdata = itc_pkg::RD_LIVE_NOACC;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_mode_reg  <= '0;
            access_mode_reg <= RST_ACCESS;
            live_reg        <= '0;
            reload_reg      <= '0;
            latched_reg     <= '0;
            latch_pend_reg  <= 1'b0;
            toggle_reg      <= 1'b0;
            running_reg     <= 1'b0;
        end else begin
            count_mode_reg  <= count_mode_next;
            access_mode_reg <= access_mode_next;
            live_reg        <= live_next;
            reload_reg      <= reload_next;
            latched_reg     <= latched_next;
            latch_pend_reg  <= latch_pend_next;
            toggle_reg      <= toggle_next;
            running_reg     <= running_next;
        end
    end

endmodule

### hdl/itc_out_buf.sv
// Result register with a skid stage so the input side keeps flowing.
// Depends on itc_pkg for the default width.
module itc_out_buf #(
    parameter int W = itc_pkg::OUT_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,    // result of an accepted transfer
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         main_valid_reg;
    logic [W-1:0] main_data_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (!main_valid_reg) begin
            main_valid_reg <= in_valid;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (main_valid_reg && out_ready) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (!main_valid_reg) begin
            main_data_reg <= in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

### hdl/interval_timer_three_counter.sv
// Top level of the three-counter interval timer: decode, counters, result buffer.
// Depends on itc_pkg, itc_counter and itc_out_buf.
//
// Takes one transfer per clock (control word, count write, count read or tick)
// and returns exactly one result per transfer through the result buffer. All
// counter state updates in the accepting cycle through short decode and
// decrement logic, so the sustained rate is one transfer per cycle. s_tready
// drops only when the result register and its skid stage both hold untaken
// results; it returns as soon as m_tready takes one. A tick steps counter 1;
// its pulse steps counter 2, whose pulse is the irq bit. Counter 0 is loaded
// and read but never stepped.
module interval_timer_three_counter #(
    parameter int NUM_COUNTERS = itc_pkg::NUM_COUNTERS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // [7:0] data_byte
    input  logic [3:0]                s_tuser,  // [1:0] op, [3:2] counter_sel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [itc_pkg::OUT_W-1:0] m_tdata   // [7:0] read_data, [8] irq, rest zero
);

    logic                     accept;
    itc_pkg::op_t             op;
    logic [1:0]               sel;
    logic [1:0]               cw_sel;
    logic [7:0]               read_data;
    logic                     irq;
    itc_pkg::cnt_cmd_t        cmd [NUM_COUNTERS];
    itc_pkg::cnt_rsp_t        rsp [NUM_COUNTERS];
    logic [itc_pkg::OUT_W-1:0] result;

    assign accept = s_tvalid && s_tready;
    assign op     = itc_pkg::op_t'(s_tuser[1:0]);
    assign sel    = s_tuser[3:2];
    assign cw_sel = s_tdata[7:6];

    // counters with per-counter command decode
    for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_cnt
        logic chain;

        // counter 1 steps on every tick, counter 2 on counter 1's pulse
        if (i == 1) begin : g_first
            assign chain = 1'b1;
        end else if (i == 2) begin : g_second
            assign chain = rsp[1].pulse;
        end else begin : g_idle
            assign chain = 1'b0;
        end

        assign cmd[i].wr_ctrl = accept && (op == itc_pkg::OP_CTRL) && (cw_sel == 2'(i));
        assign cmd[i].wr_data = accept && (op == itc_pkg::OP_DATA) && (sel == 2'(i));
        assign cmd[i].rd      = accept && (op == itc_pkg::OP_READ) && (sel == 2'(i));
        assign cmd[i].step    = accept && (op == itc_pkg::OP_TICK) && chain;

        itc_counter #(
            .RST_ACCESS((i == 2) ? itc_pkg::ACC_LATCH : itc_pkg::ACC_BOTH)
        ) u_cnt (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd[i]),
            .data_byte (s_tdata),
            .rsp       (rsp[i])
        );
    end

    // result byte: only the addressed counter drives a nonzero byte
    always_comb begin
        read_data = '0;
        for (int k = 0; k < NUM_COUNTERS; k++)
            read_data = read_data | rsp[k].rdata;
        if (op == itc_pkg::OP_READ && sel == itc_pkg::SEL_UNUSED)
            read_data = itc_pkg::RD_UNUSED_PORT;
    end

    assign irq    = rsp[2].pulse;
    assign result = {{(itc_pkg::OUT_W - 9){1'b0}}, irq, read_data};

    itc_out_buf #(
        .W(itc_pkg::OUT_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### hdl/itc_checker.sv
// Port-level checks for interval_timer_three_counter, attached by bind.
// Depends on itc_pkg.
module itc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [7:0]                s_tdata,
    input logic [3:0]                s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [itc_pkg::OUT_W-1:0] m_tdata
);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result side and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear result buffer");

    // input only stalls behind a waiting result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a transfer into an empty buffer shows up next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("result missing one cycle after transfer");

    // read byte and irq never both set; padding stays zero
    a_fmt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[8] || m_tdata[7:0] == 8'h00) && m_tdata[15:9] == 7'h00)
        else $error("malformed result");

endmodule

bind interval_timer_three_counter itc_checker u_itc_checker (.*);
